[rtl/gcd_pkg.sv]
// ----------------------------------------------------------------------------
// Great-circle distance package
// Shared constants, fixed-point widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package gcd_pkg;

    localparam int DEF_ANGLE_FRAC_BITS = 16;
    localparam int DEF_CORDIC_STAGES   = 24;
    localparam int MAX_STAGES          = 32;

    // Working width of the CORDIC datapath: Q30 values up to about 4, plus sign and margin.
    localparam int CW = 36;

    localparam logic signed [CW-1:0] Q30_ONE    = 36'sd1073741824;
    localparam logic signed [CW-1:0] Q30_PI     = 36'sd3373259426;
    localparam logic signed [CW-1:0] GAIN_INV   = 36'sd652032874;
    localparam logic [24:0]          DEG2RAD    = 25'd18740330;
    localparam logic [22:0]          EARTH_R_M  = 23'd6371000;
    localparam logic [24:0]          MAX_DIST_M = 25'd20015087;

    function automatic logic signed [CW-1:0] atan_lut(input logic [4:0] i);
        logic signed [CW-1:0] v;
        case (i)
            5'd0:  v = 36'sd843314856;
            5'd1:  v = 36'sd497837829;
            5'd2:  v = 36'sd263043836;
            5'd3:  v = 36'sd133525158;
            5'd4:  v = 36'sd67021686;
            5'd5:  v = 36'sd33543515;
            5'd6:  v = 36'sd16775850;
            5'd7:  v = 36'sd8388437;
            5'd8:  v = 36'sd4194282;
            5'd9:  v = 36'sd2097149;
            5'd10: v = 36'sd1048575;
            5'd11: v = 36'sd524287;
            5'd12: v = 36'sd262143;
            5'd13: v = 36'sd131071;
            5'd14: v = 36'sd65535;
            5'd15: v = 36'sd32767;
            5'd16: v = 36'sd16383;
            5'd17: v = 36'sd8191;
            5'd18: v = 36'sd4095;
            5'd19: v = 36'sd2047;
            5'd20: v = 36'sd1023;
            5'd21: v = 36'sd511;
            5'd22: v = 36'sd255;
            5'd23: v = 36'sd127;
            5'd24: v = 36'sd63;
            5'd25: v = 36'sd31;
            5'd26: v = 36'sd15;
            5'd27: v = 36'sd8;
            5'd28: v = 36'sd4;
            5'd29: v = 36'sd2;
            5'd30: v = 36'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // CORDIC cell payload (x, y, z), used by the rotation and vectoring cells.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } rot_t;

    typedef struct packed {
        logic valid;
        logic flip;
        logic inv_a;
        logic inv_b;
    } tag_t;

endpackage

[rtl/gcd_rot_cell.sv]
// ----------------------------------------------------------------------------
// Great-circle distance rotation cell
// One rotation-mode CORDIC iteration for a fixed shift, registered.
// ----------------------------------------------------------------------------
module gcd_rot_cell #(
    parameter int SHIFT = 0
) (
    input  logic          aclk,
    input  logic          en,
    input  gcd_pkg::rot_t d_in,
    output gcd_pkg::rot_t d_out
);
    import gcd_pkg::*;

    rot_t d_next;
    rot_t d_reg;
    logic signed [CW-1:0] atn;

    assign atn = atan_lut(5'(SHIFT));

    always_comb begin
        d_next = d_in;
        if (!d_in.z[CW-1]) begin
            d_next.x = d_in.x - (d_in.y >>> SHIFT);
            d_next.y = d_in.y + (d_in.x >>> SHIFT);
            d_next.z = d_in.z - atn;
        end else begin
            d_next.x = d_in.x + (d_in.y >>> SHIFT);
            d_next.y = d_in.y - (d_in.x >>> SHIFT);
            d_next.z = d_in.z + atn;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;
endmodule

[rtl/gcd_vec_cell.sv]
// ----------------------------------------------------------------------------
// Great-circle distance vectoring cell
// One vectoring-mode CORDIC iteration for a fixed shift, registered.
// ----------------------------------------------------------------------------
module gcd_vec_cell #(
    parameter int SHIFT = 0
) (
    input  logic          aclk,
    input  logic          en,
    input  gcd_pkg::rot_t d_in,
    output gcd_pkg::rot_t d_out
);
    import gcd_pkg::*;

    rot_t d_next;
    rot_t d_reg;
    logic signed [CW-1:0] atn;

    assign atn = atan_lut(5'(SHIFT));

    always_comb begin
        d_next = d_in;
        if (d_in.y > 0) begin
            d_next.x = d_in.x + (d_in.y >>> SHIFT);
            d_next.y = d_in.y - (d_in.x >>> SHIFT);
            d_next.z = d_in.z + atn;
        end else begin
            d_next.x = d_in.x - (d_in.y >>> SHIFT);
            d_next.y = d_in.y + (d_in.x >>> SHIFT);
            d_next.z = d_in.z - atn;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;
endmodule

[rtl/gcd_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// Great-circle distance square-root cell
// One restoring integer square-root step (one result bit), registered.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [61:0] rem_in,
    input  logic [30:0] root_in,
    input  logic [35:0] side_in,
    output logic [61:0] rem_out,
    output logic [30:0] root_out,
    output logic [35:0] side_out
);
    localparam int BPOS = 60 - 2 * STEP;

    logic [61:0] rem_next;
    logic [30:0] root_next;
    logic [61:0] trial;
    logic [61:0] rem_reg;
    logic [30:0] root_reg;
    logic [35:0] side_reg;

    // Root bits so far placed at weight 2^(30-STEP); the trial is (2r+1)*2^(BPOS).
    assign trial = ({31'd0, root_in} << (31 - STEP)) | (62'd1 << BPOS);

    always_comb begin
        if (rem_in >= trial) begin
            rem_next  = rem_in - trial;
            root_next = root_in | (31'd1 << (30 - STEP));
        end else begin
            rem_next  = rem_in;
            root_next = root_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;
endmodule

[rtl/great_circle_distance.sv]
// ----------------------------------------------------------------------------
// Great-circle distance
// Spherical law of cosines on two points, pipelined CORDIC and square-root cells.
// ----------------------------------------------------------------------------
// Channel | Dir | Payload
// s_axis  | in  | tdata: start_lat, start_lon, end_lat, end_lon
// m_axis  | out | tdata: distance_m; tuser: start_invalid, end_invalid
//
// One item is accepted every cycle while m_axis does not stall the pipeline.
// The pipeline advances as one whole when the output register is empty or
// taken, so a stall at m_axis holds every stage in place.
// Reset clears only the valid bits of the stages.
// ----------------------------------------------------------------------------
module great_circle_distance #(
    parameter int ANGLE_FRAC_BITS = gcd_pkg::DEF_ANGLE_FRAC_BITS,
    parameter int CORDIC_STAGES   = gcd_pkg::DEF_CORDIC_STAGES
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // start_lat, start_lon, end_lat, end_lon
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata,  // distance_m
    output logic [1:0]   m_axis_tuser   // start_invalid, end_invalid
);
    import gcd_pkg::*;

    localparam int NS    = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    localparam int SQ    = 31;
    localparam int NPIPE = 2 * NS + SQ + 10;

    logic en;
    tag_t tag_pipe [NPIPE+1];

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 0: range check, longitude fold.
    logic signed [23:0] la, lb;
    logic signed [24:0] loa, lob;
    logic signed [CW-1:0] lat_lim, lon_lim;
    logic signed [CW-1:0] dd;
    logic bad_a, bad_b, flip0;
    logic signed [CW-1:0] s0_la_reg, s0_lb_reg, s0_d_reg;

    assign la  = s_axis_tdata[23:0];
    assign loa = s_axis_tdata[48:24];
    assign lb  = s_axis_tdata[72:49];
    assign lob = s_axis_tdata[97:73];
    assign lat_lim = CW'(90) <<< ANGLE_FRAC_BITS;
    assign lon_lim = CW'(180) <<< ANGLE_FRAC_BITS;

    always_comb begin
        logic signed [CW-1:0] t;
        bad_a = (CW'(la) < -lat_lim) || (CW'(la) > lat_lim)
             || (CW'(loa) < -lon_lim) || (CW'(loa) > lon_lim);
        bad_b = (CW'(lb) < -lat_lim) || (CW'(lb) > lat_lim)
             || (CW'(lob) < -lon_lim) || (CW'(lob) > lon_lim);
        t = CW'(lob) - CW'(loa);
        if (t < 0) begin
            t = -t;
        end
        if (t > lon_lim) begin
            t = (lon_lim <<< 1) - t;
        end
        flip0 = 1'b0;
        if (t > lat_lim) begin
            t = lon_lim - t;
            flip0 = 1'b1;
        end
        dd = t;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_la_reg <= CW'(la);
            s0_lb_reg <= CW'(lb);
            s0_d_reg  <= dd;
        end
    end

    assign tag_pipe[0] = '{valid: s_axis_tvalid, flip: flip0, inv_a: bad_a, inv_b: bad_b};

    genvar g;
    generate
        for (g = 0; g < NPIPE; g++) begin : g_tag
            tag_t t_reg;
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    t_reg.valid <= 1'b0;
                end else if (en) begin
                    t_reg.valid <= tag_pipe[g].valid;
                end
                if (en) begin
                    t_reg.flip  <= tag_pipe[g].flip;
                    t_reg.inv_a <= tag_pipe[g].inv_a;
                    t_reg.inv_b <= tag_pipe[g].inv_b;
                end
            end
            assign tag_pipe[g+1] = t_reg;
        end
    endgenerate

    // Stage 1: degrees to radians, three products.
    function automatic logic signed [CW-1:0] d2r(input logic signed [CW-1:0] d);
        logic [CW-1:0] mag;
        logic [63:0]   p;
        logic [63:0]   r;
        mag = d[CW-1] ? CW'(-d) : d;
        p = 64'(mag[24:0]) * 64'(DEG2RAD);
        r = (p + (64'd1 << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS;
        return d[CW-1] ? -CW'(r) : CW'(r);
    endfunction

    rot_t ra_reg, rb_reg, rd_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            ra_reg <= '{x: GAIN_INV, y: '0, z: d2r(s0_la_reg)};
            rb_reg <= '{x: GAIN_INV, y: '0, z: d2r(s0_lb_reg)};
            rd_reg <= '{x: GAIN_INV, y: '0, z: d2r(s0_d_reg)};
        end
    end

    // Stages 2..NS+1: rotation cells.
    rot_t ca [NS+1];
    rot_t cb [NS+1];
    rot_t cd [NS+1];
    assign ca[0] = ra_reg;
    assign cb[0] = rb_reg;
    assign cd[0] = rd_reg;
    generate
        for (g = 0; g < NS; g++) begin : g_rot
            gcd_rot_cell #(.SHIFT(g)) u_a (.aclk(aclk), .en(en), .d_in(ca[g]), .d_out(ca[g+1]));
            gcd_rot_cell #(.SHIFT(g)) u_b (.aclk(aclk), .en(en), .d_in(cb[g]), .d_out(cb[g+1]));
            gcd_rot_cell #(.SHIFT(g)) u_d (.aclk(aclk), .en(en), .d_in(cd[g]), .d_out(cd[g+1]));
        end
    endgenerate

    localparam int TR = NS + 2;

    // Products sa*sb and ca*cb, registered.
    logic signed [71:0] ssp_reg, ccp_reg;
    logic signed [CW-1:0] cdv_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            ssp_reg <= 72'(ca[NS].y) * 72'(cb[NS].y);
            ccp_reg <= 72'(ca[NS].x) * 72'(cb[NS].x);
            cdv_reg <= tag_pipe[TR].flip ? -cd[NS].x : cd[NS].x;
        end
    end

    logic signed [71:0] ss2_reg, cc_reg;
    logic signed [CW-1:0] cd2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            ss2_reg <= ssp_reg;
            cc_reg  <= (ccp_reg + 72'sd536870912) >>> 30;
            cd2_reg <= cdv_reg;
        end
    end

    logic signed [71:0] ccd_reg, ss3_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            ccd_reg <= 72'($signed(cc_reg[CW-1:0])) * 72'(cd2_reg);
            ss3_reg <= ss2_reg;
        end
    end

    // Round, clamp, square.
    logic signed [CW-1:0] c_reg;
    always_ff @(posedge aclk) begin
        logic signed [71:0] s;
        s = (ss3_reg + ccd_reg + 72'sd536870912) >>> 30;
        if (en) begin
            if (s > 72'(Q30_ONE)) begin
                c_reg <= Q30_ONE;
            end else if (s < -72'(Q30_ONE)) begin
                c_reg <= -Q30_ONE;
            end else begin
                c_reg <= s[CW-1:0];
            end
        end
    end

    logic [30:0] m_reg;
    logic        neg_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg   <= c_reg[CW-1] ? 31'(-c_reg) : c_reg[30:0];
            neg_reg <= c_reg[CW-1];
        end
    end

    logic [61:0] rad_reg;
    logic [35:0] side0_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg   <= (62'd1 << 60) - 62'(m_reg) * 62'(m_reg);
            side0_reg <= {4'd0, neg_reg, m_reg};
        end
    end

    logic [61:0] srem [SQ+1];
    logic [30:0] sroot [SQ+1];
    logic [35:0] sside [SQ+1];
    assign srem[0]  = rad_reg;
    assign sroot[0] = '0;
    assign sside[0] = side0_reg;
    generate
        for (g = 0; g < SQ; g++) begin : g_sqrt
            gcd_sqrt_cell #(.STEP(g)) u_s (
                .aclk(aclk), .en(en),
                .rem_in(srem[g]), .root_in(sroot[g]), .side_in(sside[g]),
                .rem_out(srem[g+1]), .root_out(sroot[g+1]), .side_out(sside[g+1])
            );
        end
    endgenerate

    // Vectoring cells for the arc cosine; the negation flag travels beside them.
    rot_t vc [NS+1];
    logic neg_pipe [NS+1];
    assign vc[0] = '{x: CW'(sside[SQ][30:0]), y: CW'(sroot[SQ]), z: '0};
    assign neg_pipe[0] = sside[SQ][31];
    generate
        for (g = 0; g < NS; g++) begin : g_vec
            logic n_reg;
            gcd_vec_cell #(.SHIFT(g)) u_v (.aclk(aclk), .en(en), .d_in(vc[g]), .d_out(vc[g+1]));
            always_ff @(posedge aclk) begin
                if (en) begin
                    n_reg <= neg_pipe[g];
                end
            end
            assign neg_pipe[g+1] = n_reg;
        end
    endgenerate

    logic signed [CW-1:0] ang_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg <= neg_pipe[NS] ? Q30_PI - vc[NS].z : vc[NS].z;
        end
    end

    logic signed [63:0] prod_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= 64'(ang_reg) * 64'(EARTH_R_M);
        end
    end

    // Output register.
    localparam int TO = NPIPE;
    logic [24:0] dist_reg;
    logic [1:0]  flags_reg;
    logic        ovalid_reg;
    always_ff @(posedge aclk) begin
        logic signed [63:0] r;
        r = (prod_reg + 64'sd536870912) >>> 30;
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (en) begin
            ovalid_reg <= tag_pipe[TO].valid;
        end
        if (en) begin
            flags_reg <= {tag_pipe[TO].inv_b, tag_pipe[TO].inv_a};
            if (tag_pipe[TO].inv_a || tag_pipe[TO].inv_b || r < 0) begin
                dist_reg <= '0;
            end else if (r > 64'(MAX_DIST_M)) begin
                dist_reg <= MAX_DIST_M;
            end else begin
                dist_reg <= r[24:0];
            end
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {7'd0, dist_reg};
    assign m_axis_tuser  = flags_reg;
endmodule

[rtl/gcd_checker.sv]
// ----------------------------------------------------------------------------
// Great-circle distance checker
// Port-level properties of the block, bound to the top level.
// ----------------------------------------------------------------------------
module gcd_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [31:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output side");

    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser != 2'b00) |-> m_axis_tdata == 32'd0)
        else $error("flagged item has nonzero distance");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata <= 32'd20015087)
        else $error("distance out of range");
endmodule

bind great_circle_distance gcd_checker u_gcd_checker (.*);
